>>> design/pvst_pkg.sv
// Shared types and constants for the visual servo tracker.
`timescale 1ns / 1ps

package pvst_pkg;

    localparam int GAIN_W     = 16;
    localparam int BAND_W     = 8;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int TARGET_W   = 18;
    localparam int AIM_W      = 17;
    localparam int DTERM_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DTERM_LIMIT = 40;
    localparam int AIM_Y_MIN   = -64000;
    localparam int AIM_Y_MAX   = 64000;
    localparam int AIM_Z_MIN   = 44800;
    localparam int AIM_Z_MAX   = 76800;
    localparam int AIM_Z_RESET = 51200;

    localparam logic [GAIN_W-1:0] GAIN_P_RST       = 16'd410;
    localparam logic [GAIN_W-1:0] GAIN_D_RST       = 16'd410;
    localparam int                CENTER_X_RST     = 160;
    localparam int                CENTER_Y_RST     = 120;
    localparam logic [BAND_W-1:0] LOCK_BAND_RST    = 8'd10;
    localparam logic [BAND_W-1:0] RELEASE_BAND_RST = 8'd16;
    localparam logic [MS_W-1:0]   LOST_TIMEOUT_RST = 16'd300;
    localparam logic [MS_W-1:0]   STROBE_GAP_RST   = 16'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_D        = 3'd1,
        CFG_CENTER_X      = 3'd2,
        CFG_CENTER_Y      = 3'd3,
        CFG_LOCK_BAND     = 3'd4,
        CFG_RELEASE_BAND  = 3'd5,
        CFG_LOST_TIMEOUT  = 3'd6,
        CFG_STROBE_GAP    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_d;
        logic [BAND_W-1:0] lock_band;
        logic [BAND_W-1:0] release_band;
        logic [MS_W-1:0]   lost_limit_ms;
        logic [MS_W-1:0]   strobe_gap_ms;
    } cfg_t;

endpackage

>>> design/pvst_cfg_regs.sv
// Configuration register file for the visual servo tracker.
`timescale 1ns / 1ps

module pvst_cfg_regs
    import pvst_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic [PIXEL_BITS-1:0] center_x,
    output logic [PIXEL_BITS-1:0] center_y
);

    cfg_t                  cfg_reg;
    logic [PIXEL_BITS-1:0] center_x_reg;
    logic [PIXEL_BITS-1:0] center_y_reg;
    cfg_reg_t              idx;

    assign idx = cfg_reg_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p        <= GAIN_P_RST;
            cfg_reg.gain_d        <= GAIN_D_RST;
            cfg_reg.lock_band     <= LOCK_BAND_RST;
            cfg_reg.release_band  <= RELEASE_BAND_RST;
            cfg_reg.lost_limit_ms <= LOST_TIMEOUT_RST;
            cfg_reg.strobe_gap_ms <= STROBE_GAP_RST;
            center_x_reg          <= PIXEL_BITS'(CENTER_X_RST);
            center_y_reg          <= PIXEL_BITS'(CENTER_Y_RST);
        end else if (cfg_valid) begin
            unique case (idx)
                CFG_GAIN_P:       cfg_reg.gain_p        <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:       cfg_reg.gain_d        <= cfg_data[GAIN_W-1:0];
                CFG_CENTER_X:     center_x_reg          <= cfg_data[PIXEL_BITS-1:0];
                CFG_CENTER_Y:     center_y_reg          <= cfg_data[PIXEL_BITS-1:0];
                CFG_LOCK_BAND:    cfg_reg.lock_band     <= cfg_data[BAND_W-1:0];
                CFG_RELEASE_BAND: cfg_reg.release_band  <= cfg_data[BAND_W-1:0];
                CFG_LOST_TIMEOUT: cfg_reg.lost_limit_ms <= cfg_data[MS_W-1:0];
                CFG_STROBE_GAP:   cfg_reg.strobe_gap_ms <= cfg_data[MS_W-1:0];
                default:          cfg_reg.gain_p        <= cfg_reg.gain_p;
            endcase
        end
    end

    assign cfg      = cfg_reg;
    assign center_x = center_x_reg;
    assign center_y = center_y_reg;

endmodule

>>> design/pvst_core.sv
// PD step with lock hysteresis, target clamps, move timer and the result register.
`timescale 1ns / 1ps

module pvst_core
    import pvst_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  cfg_t                    cfg,
    input  logic [PIXEL_BITS-1:0]   center_x,
    input  logic [PIXEL_BITS-1:0]   center_y,
    input  logic [PIXEL_BITS-1:0]   col,
    input  logic [PIXEL_BITS-1:0]   row,
    input  logic [TIME_W-1:0]       now,
    output logic signed [AIM_W-1:0] aim_y,
    output logic [AIM_W-1:0]        aim_z,
    output logic                    move_strobe,
    output logic                    locked
);

    localparam int ERR_W = PIXEL_BITS + 1;
    localparam int DX_W  = PIXEL_BITS + 2;
    localparam int SUM_W = PIXEL_BITS + 18;
    localparam int STEP_W = SUM_W - 4;
    localparam int ACC_W = STEP_W + 1;

    localparam logic signed [DX_W-1:0]    DLIM_HI = DX_W'(DTERM_LIMIT);
    localparam logic signed [DX_W-1:0]    DLIM_LO = DX_W'(-DTERM_LIMIT);
    localparam logic signed [ACC_W-1:0]   Y_MIN   = ACC_W'(AIM_Y_MIN);
    localparam logic signed [ACC_W-1:0]   Y_MAX   = ACC_W'(AIM_Y_MAX);
    localparam logic signed [ACC_W-1:0]   Z_MIN   = ACC_W'(AIM_Z_MIN);
    localparam logic signed [ACC_W-1:0]   Z_MAX   = ACC_W'(AIM_Z_MAX);
    localparam logic signed [SUM_W-1:0]   RND     = SUM_W'(8);

    // tracking state
    logic signed [ERR_W-1:0]    prev_err_x_reg, prev_err_y_reg;
    logic signed [TARGET_W-1:0] target_y_reg, target_z_reg;
    logic                       lock_reg;
    logic [TIME_W-1:0]          last_seen_reg, last_move_reg;
    // result register
    logic signed [AIM_W-1:0]    aim_y_reg;
    logic [AIM_W-1:0]           aim_z_reg;
    logic                       strobe_reg, locked_reg;

    logic signed [ERR_W-1:0]    ex, ey, pex, pey;
    logic [ERR_W-1:0]           ax, ay, bx_rel, bx_lock;
    logic [TIME_W-1:0]          seen_gap, move_gap;
    logic                       lost, hold, enter, due;
    logic signed [DX_W-1:0]     dx, dy;
    logic signed [DTERM_W-1:0]  dx_c, dy_c;
    logic signed [GAIN_W:0]     gp_s, gd_s;
    logic signed [SUM_W-1:0]    prod_px, prod_py, prod_dx, prod_dy, sum_y, sum_z;
    logic signed [STEP_W-1:0]   step_y, step_z;
    logic signed [ACC_W-1:0]    acc_y, acc_z;
    logic signed [TARGET_W-1:0] clamp_y, clamp_z, ty_next, tz_next;

    always_comb begin
        ex = $signed({1'b0, center_x}) - $signed({1'b0, col});
        ey = $signed({1'b0, center_y}) - $signed({1'b0, row});
        ax = ex[ERR_W-1] ? ERR_W'(-ex) : ex;
        ay = ey[ERR_W-1] ? ERR_W'(-ey) : ey;
        bx_rel  = ERR_W'(cfg.release_band);
        bx_lock = ERR_W'(cfg.lock_band);

        seen_gap = now - last_seen_reg;
        move_gap = now - last_move_reg;
        lost = seen_gap > TIME_W'(cfg.lost_limit_ms);
        due  = move_gap >= TIME_W'(cfg.strobe_gap_ms);

        // a held lock zeroes the errors, which always re-enters the lock band
        hold  = lock_reg && (ax <= bx_rel) && (ay <= bx_rel);
        enter = hold || ((ax <= bx_lock) && (ay <= bx_lock));

        pex = lost ? '0 : prev_err_x_reg;
        pey = lost ? '0 : prev_err_y_reg;
        dx = DX_W'(ex) - DX_W'(pex);
        dy = DX_W'(ey) - DX_W'(pey);
        priority if (dx > DLIM_HI) dx_c = DTERM_W'(DTERM_LIMIT);
        else if (dx < DLIM_LO)     dx_c = DTERM_W'(-DTERM_LIMIT);
        else                       dx_c = dx[DTERM_W-1:0];
        priority if (dy > DLIM_HI) dy_c = DTERM_W'(DTERM_LIMIT);
        else if (dy < DLIM_LO)     dy_c = DTERM_W'(-DTERM_LIMIT);
        else                       dy_c = dy[DTERM_W-1:0];

        gp_s = $signed({1'b0, cfg.gain_p});
        gd_s = $signed({1'b0, cfg.gain_d});
        prod_px = ex * gp_s;
        prod_py = ey * gp_s;
        prod_dx = dx_c * gd_s;
        prod_dy = dy_c * gd_s;
        sum_y = prod_px + prod_dx + RND;
        sum_z = prod_py + prod_dy + RND;
        // floor divide by 16: Q.12 to Q.8, ties toward +inf after the +8
        step_y = sum_y[SUM_W-1:4];
        step_z = sum_z[SUM_W-1:4];

        acc_y = ACC_W'(target_y_reg) + ACC_W'(step_y);
        acc_z = ACC_W'(target_z_reg) + ACC_W'(step_z);
        priority if (acc_y < Y_MIN) clamp_y = TARGET_W'(AIM_Y_MIN);
        else if (acc_y > Y_MAX)     clamp_y = TARGET_W'(AIM_Y_MAX);
        else                        clamp_y = acc_y[TARGET_W-1:0];
        priority if (acc_z < Z_MIN) clamp_z = TARGET_W'(AIM_Z_MIN);
        else if (acc_z > Z_MAX)     clamp_z = TARGET_W'(AIM_Z_MAX);
        else                        clamp_z = acc_z[TARGET_W-1:0];

        ty_next = enter ? target_y_reg : clamp_y;
        tz_next = enter ? target_z_reg : clamp_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_x_reg <= '0;
            prev_err_y_reg <= '0;
            target_y_reg   <= '0;
            target_z_reg   <= TARGET_W'(AIM_Z_RESET);
            lock_reg       <= 1'b0;
            last_seen_reg  <= '0;
            last_move_reg  <= '0;
        end else if (fire) begin
            last_seen_reg <= now;
            lock_reg      <= enter;
            target_y_reg  <= ty_next;
            target_z_reg  <= tz_next;
            if (enter) begin
                prev_err_x_reg <= '0;
                prev_err_y_reg <= '0;
            end else begin
                prev_err_x_reg <= ex;
                prev_err_y_reg <= ey;
                if (due) begin
                    last_move_reg <= now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            aim_y_reg  <= ty_next[AIM_W-1:0];
            aim_z_reg  <= tz_next[AIM_W-1:0];
            strobe_reg <= !enter && due;
            locked_reg <= enter;
        end
    end

    assign aim_y       = aim_y_reg;
    assign aim_z       = aim_z_reg;
    assign move_strobe = strobe_reg;
    assign locked      = locked_reg;

endmodule

>>> design/pd_visual_servo_tracker.sv
// Visual servo tracker top level: handshake, input register, configuration registers and core.
`timescale 1ns / 1ps

// Takes one detected target centre with a millisecond timestamp per
// transaction and returns one result: the clamped Y/Z aim targets in Q.8 mm,
// a rate-limited move strobe and the lock flag. One transaction is accepted
// every clock cycle while the result side does not stall; a result passes
// through the input register, then the PD step into the result register,
// which also updates the tracking state. Throughput is set by that state
// update loop. Configuration writes are always accepted and are meant to be
// done while no transaction is in flight. There is no start-up clearing pass.
module pd_visual_servo_tracker
    import pvst_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PIXEL_BITS-1:0]   s_center_col,
    input  logic [PIXEL_BITS-1:0]   s_center_row,
    input  logic [TIME_W-1:0]       s_time_ms,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [AIM_W-1:0] m_aim_y,
    output logic [AIM_W-1:0]        m_aim_z,
    output logic                    m_move_strobe,
    output logic                    m_locked,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t                  cfg;
    logic [PIXEL_BITS-1:0] center_x, center_y;

    logic                  in_valid_reg;
    logic [PIXEL_BITS-1:0] col_reg, row_reg;
    logic [TIME_W-1:0]     time_reg;
    logic                  out_valid_reg;
    logic                  advance, take;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign take      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            col_reg  <= s_center_col;
            row_reg  <= s_center_row;
            time_reg <= s_time_ms;
        end
    end

    pvst_cfg_regs #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .center_x (center_x),
        .center_y (center_y)
    );

    pvst_core #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .cfg        (cfg),
        .center_x   (center_x),
        .center_y   (center_y),
        .col        (col_reg),
        .row        (row_reg),
        .now        (time_reg),
        .aim_y      (m_aim_y),
        .aim_z      (m_aim_z),
        .move_strobe(m_move_strobe),
        .locked     (m_locked)
    );

    assign m_valid = out_valid_reg;

    // a locked result never carries a move strobe
    a_lock_no_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_locked && m_move_strobe))
        else $error("locked result with move strobe");

    a_aim_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_aim_z >= AIM_W'(AIM_Z_MIN)) && (m_aim_z <= AIM_W'(AIM_Z_MAX)))
        else $error("aim_z out of range");

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("stepped transaction produced no result");

    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result without a pending transaction");

endmodule

>>> test/tb_pd_visual_servo_tracker.sv
// Self-checking testbench for the visual servo tracker: PD step, deadband and move strobe.
`timescale 1ns / 1ps

module tb_pd_visual_servo_tracker;
    import pvst_pkg::*;

    localparam int PIX_W       = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_center_col = '0;
    logic [PIX_W-1:0]        s_center_row = '0;
    logic [TIME_W-1:0]       s_time_ms = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [AIM_W-1:0] m_aim_y;
    logic [AIM_W-1:0]        m_aim_z;
    logic                    m_move_strobe;
    logic                    m_locked;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    bit          hold_req = 1'b0;
    bit          quiet = 1'b0;
    bit [31:0]   now_ms = '0;
    int unsigned cycle_count = 0;

    typedef struct {
        int aim_y;
        int aim_z;
        bit strobe;
        bit locked;
    } aim_t;

    class aim_scoreboard;
        bit [GAIN_W-1:0] gain_p, gain_d;
        bit [PIX_W-1:0]  center_x, center_y;
        bit [BAND_W-1:0] lock_band, release_band;
        bit [MS_W-1:0]   lost_timeout, strobe_gap;

        int        prev_ex, prev_ey;
        int        aim_y_acc, aim_z_acc;
        bit        lock_on;
        bit [31:0] last_seen, last_move;

        aim_t pending_aims[$];
        int   errors;
        int   checked;

        function new();
            gain_p        = GAIN_P_RST;
            gain_d        = GAIN_D_RST;
            center_x      = PIX_W'(CENTER_X_RST);
            center_y      = PIX_W'(CENTER_Y_RST);
            lock_band     = LOCK_BAND_RST;
            release_band  = RELEASE_BAND_RST;
            lost_timeout  = LOST_TIMEOUT_RST;
            strobe_gap    = STROBE_GAP_RST;
            prev_ex   = 0;
            prev_ey   = 0;
            aim_y_acc = 0;
            aim_z_acc = AIM_Z_RESET;
            lock_on   = 1'b0;
            last_seen = '0;
            last_move = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GAIN_P:       gain_p = value;
                CFG_GAIN_D:       gain_d = value;
                CFG_CENTER_X:     center_x = value[PIX_W-1:0];
                CFG_CENTER_Y:     center_y = value[PIX_W-1:0];
                CFG_LOCK_BAND:    lock_band = value[BAND_W-1:0];
                CFG_RELEASE_BAND: release_band = value[BAND_W-1:0];
                CFG_LOST_TIMEOUT: lost_timeout = value;
                CFG_STROBE_GAP:   strobe_gap = value;
                default: ;
            endcase
        endfunction

        function int iabs(int v);
            return v < 0 ? -v : v;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Q.12 -> Q.8, round half toward +inf (floor of (v + 8) / 16)
        function longint round_to_q8(longint q12);
            return (q12 + 64'sd8) >>> 4;
        endfunction

        function void note_detection(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                     logic [31:0] stamp);
            int        ex, ey, dx, dy;
            longint    sum_y, sum_z;
            bit [31:0] gap;
            bit        strobe;
            aim_t      want;
            ex = int'(center_x) - int'(col);
            ey = int'(center_y) - int'(row);
            strobe = 1'b0;

            gap = stamp - last_seen;
            if (gap > 32'(lost_timeout)) begin
                prev_ex = 0;
                prev_ey = 0;
            end
            last_seen = stamp;

            if (lock_on) begin
                if (iabs(ex) <= int'(release_band) && iabs(ey) <= int'(release_band)) begin
                    ex = 0;
                    ey = 0;
                end else begin
                    lock_on = 1'b0;
                end
            end

            if (iabs(ex) <= int'(lock_band) && iabs(ey) <= int'(lock_band)) begin
                lock_on = 1'b1;
                prev_ex = 0;
                prev_ey = 0;
            end else begin
                dx = int'(clip(longint'(ex - prev_ex), -DTERM_LIMIT, DTERM_LIMIT));
                dy = int'(clip(longint'(ey - prev_ey), -DTERM_LIMIT, DTERM_LIMIT));
                sum_y = longint'(ex) * longint'(gain_p) + longint'(dx) * longint'(gain_d);
                sum_z = longint'(ey) * longint'(gain_p) + longint'(dy) * longint'(gain_d);
                prev_ex = ex;
                prev_ey = ey;
                aim_y_acc = int'(clip(longint'(aim_y_acc) + round_to_q8(sum_y),
                                      AIM_Y_MIN, AIM_Y_MAX));
                aim_z_acc = int'(clip(longint'(aim_z_acc) + round_to_q8(sum_z),
                                      AIM_Z_MIN, AIM_Z_MAX));
                gap = stamp - last_move;
                if (gap >= 32'(strobe_gap)) begin
                    strobe = 1'b1;
                    last_move = stamp;
                end
            end

            want.aim_y  = aim_y_acc;
            want.aim_z  = aim_z_acc;
            want.strobe = strobe;
            want.locked = lock_on;
            pending_aims.push_back(want);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 200)
                $display("MISMATCH result %0d: %s", checked, what);
        endtask

        task check_aim(logic signed [AIM_W-1:0] y, logic [AIM_W-1:0] z,
                       logic strobe, logic lock);
            aim_t want;
            checked++;
            if (pending_aims.size() == 0) begin
                report("result transaction with no detection pending");
                return;
            end
            want = pending_aims.pop_front();
            if (y !== AIM_W'(want.aim_y))
                report($sformatf("aim_y got %0d want %0d", y, want.aim_y));
            if (z !== AIM_W'(want.aim_z))
                report($sformatf("aim_z got %0d want %0d", z, want.aim_z));
            if (strobe !== want.strobe)
                report($sformatf("move_strobe got %b want %b", strobe, want.strobe));
            if (lock !== want.locked)
                report($sformatf("locked got %b want %b", lock, want.locked));
        endtask
    endclass

    aim_scoreboard sb;

    pd_visual_servo_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_center_col  (s_center_col),
        .s_center_row  (s_center_row),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_aim_y       (m_aim_y),
        .m_aim_z       (m_aim_z),
        .m_move_strobe (m_move_strobe),
        .m_locked      (m_locked),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_aim(m_aim_y, m_aim_z, m_move_strobe, m_locked);
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // valid stays high after acceptance; the next call or a pause decides
    task automatic send_detection(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                                  input logic [31:0] stamp);
        s_valid      <= 1'b1;
        s_center_col <= col;
        s_center_row <= row;
        s_time_ms    <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_detection(col, row, stamp);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_aims.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] gp, gd, cx, cy,
                                 input logic [CFG_DATA_W-1:0] lb, rb, lost, interval);
        drain();
        repeat (2) @(posedge aclk);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_LOCK_BAND, lb);
        write_reg(CFG_RELEASE_BAND, rb);
        write_reg(CFG_LOST_TIMEOUT, lost);
        write_reg(CFG_STROBE_GAP, interval);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit with_idles,
                             input int hold_at, input int drain_at);
        int mode, left, col, row, reach, sel;
        left = 0;
        mode = 0;
        col  = 0;
        row  = 0;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_req = 1'b1;
            if (n == drain_at)
                drain();
            if (left == 0) begin
                mode = $urandom_range(0, 9);
                left = $urandom_range(8, 30);
                col  = $urandom_range(0, 4095);
                row  = $urandom_range(0, 4095);
            end
            left--;
            reach = (sb.lock_band > sb.release_band ? int'(sb.lock_band)
                                                    : int'(sb.release_band)) + 3;
            if (mode < 5) begin
                // target drifts in toward the centre and settles in the deadband
                col = col + (int'(sb.center_x) - col) / 3 + spread(2);
                row = row + (int'(sb.center_y) - row) / 3 + spread(2);
            end else if (mode < 8) begin
                col = int'(sb.center_x) + spread(reach);
                row = int'(sb.center_y) + spread(reach);
            end else begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
            end
            col &= 4095;
            row &= 4095;

            sel = $urandom_range(0, 99);
            if (sel < 65)
                now_ms += $urandom_range(1, 40);
            else if (sel < 80)
                now_ms += $urandom_range(40, 700);
            else if (sel < 90)
                now_ms += $urandom_range(700, 70000);
            else if (sel < 95)
                now_ms = $urandom();

            send_detection(col[PIX_W-1:0], row[PIX_W-1:0], now_ms);
            if (with_idles && !hold_req && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 14));
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: extremes, lost timeout edge, lock/hold/release, time wrap
        send_detection(12'd0, 12'd0, 32'd5);
        send_detection(12'd4095, 12'd4095, 32'd40);
        send_detection(12'd4095, 12'd0, 32'd41);
        send_detection(12'd0, 12'd4095, 32'd341);
        send_detection(12'd160, 12'd120, 32'd642);
        send_detection(12'd165, 12'd115, 32'd650);
        send_detection(12'd176, 12'd104, 32'd660);
        send_detection(12'd177, 12'd120, 32'd670);
        send_detection(12'd150, 12'd130, 32'd680);
        send_detection(12'd144, 12'd120, 32'd690);
        send_detection(12'd160, 12'd137, 32'd710);
        send_detection(12'd171, 12'd120, 32'd720);
        send_detection(12'd100, 12'd200, 32'hFFFF_FFF0);
        send_detection(12'd100, 12'd200, 32'h0000_000E);
        send_detection(12'd100, 12'd200, 32'h0000_002A);
        send_detection(12'd300, 12'd20, 32'h0000_002A);
        send_detection(12'd4095, 12'd4095, 32'h0000_002B);
        send_detection(12'd0, 12'd0, 32'h0000_002C);
        send_detection(12'd4095, 12'd2048, 32'h0000_002D);
        send_detection(12'd2048, 12'd4095, 32'h0000_002E);
        now_ms = 32'h0000_002E;

        // upper data bits set on narrow registers to exercise masking
        apply_setting(16'd4096, 16'd2048, 16'hF7D0, 16'h93E8, 16'hAB05, 16'h110C,
                      16'd100, 16'd0);
        run_phase(150, 1'b1, 40, -1);

        apply_setting(16'hFFFF, 16'hFFFF, 16'h0FFF, 16'hFFFF, 16'h00FF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF);
        run_phase(120, 1'b1, -1, -1);

        apply_setting(16'd0, 16'hFFFF, 16'd0, 16'hF000, 16'd0, 16'hFF00, 16'd0, 16'd0);
        run_phase(120, 1'b1, -1, -1);

        // lock band wider than release band
        apply_setting(16'd300, 16'd800, 16'd160, 16'd120, 16'd30, 16'd8, 16'd500, 16'd50);
        run_phase(150, 1'b1, -1, 75);

        apply_setting(CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(0, 65535)));
        run_phase(150, 1'b1, -1, -1);

        apply_setting(GAIN_P_RST, GAIN_D_RST, CFG_DATA_W'(CENTER_X_RST),
                      CFG_DATA_W'(CENTER_Y_RST), CFG_DATA_W'(LOCK_BAND_RST),
                      CFG_DATA_W'(RELEASE_BAND_RST), LOST_TIMEOUT_RST, STROBE_GAP_RST);
        quiet = 1'b1;
        run_phase(200, 1'b0, -1, -1);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_aims.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
